[rtl/alle_pkg.sv]
// ----------------------------------------------------------------------------
// alle_pkg
// Types, codes and field widths shared by the linked list engine modules.
// ----------------------------------------------------------------------------
package alle_pkg;

  localparam int IDX_W  = 8;
  localparam int VAL_W  = 8;
  localparam int SLOT_W = 8;
  localparam int CNT_W  = 8;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_FIND   = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOMEM  = 2'd1,
    ST_BADIDX = 2'd2
  } status_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] index;
    logic [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic              linear;
    logic [CNT_W-1:0]  count;
  } out_item_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_INS_B,
    S_INS_C,
    S_INS_D,
    S_REM_B,
    S_REM_C,
    S_FIND_B,
    S_RESP
  } state_t;

  // controller to datapath strobes
  typedef struct packed {
    logic init_wr;
    logic load;
    logic decode;
    logic ins_b;
    logic ins_c;
    logic ins_d;
    logic rem_b;
    logic rem_c;
    logic find_step;
    logic resp_load;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    op_t  op;
    logic ins_ok;
    logic rem_ok;
    logic find_go;
    logic find_last;
    logic init_last;
  } dp_sts_t;

endpackage

[rtl/alle_ctrl.sv]
// ----------------------------------------------------------------------------
// alle_ctrl
// Sequencer for the linked list engine: init sweep, per-operation link steps
// and the result register handshake.
// ----------------------------------------------------------------------------
module alle_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  alle_pkg::dp_sts_t sts,
  output alle_pkg::dp_cmd_t cmd
);
  import alle_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT: begin
        if (sts.init_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (sts.op)
          OP_INSERT: state_nxt = sts.ins_ok  ? S_INS_B  : S_RESP;
          OP_REMOVE: state_nxt = sts.rem_ok  ? S_REM_B  : S_RESP;
          OP_FIND:   state_nxt = sts.find_go ? S_FIND_B : S_RESP;
          default:   state_nxt = S_RESP;
        endcase
      end
      S_INS_B:  state_nxt = S_INS_C;
      S_INS_C:  state_nxt = S_INS_D;
      S_INS_D:  state_nxt = S_RESP;
      S_REM_B:  state_nxt = S_REM_C;
      S_REM_C:  state_nxt = S_RESP;
      S_FIND_B: begin
        if (sts.find_last) state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_INIT;
    endcase
  end

  // outputs
  always_comb begin
    cmd           = '0;
    cmd.init_wr   = (state_r == S_INIT);
    cmd.load      = (state_r == S_IDLE) && in_valid;
    cmd.decode    = (state_r == S_DECODE);
    cmd.ins_b     = (state_r == S_INS_B);
    cmd.ins_c     = (state_r == S_INS_C);
    cmd.ins_d     = (state_r == S_INS_D);
    cmd.rem_b     = (state_r == S_REM_B);
    cmd.rem_c     = (state_r == S_REM_C);
    cmd.find_step = (state_r == S_FIND_B);
    cmd.resp_load = (state_r == S_RESP) && (!out_valid_r || !out_stall);

    if (cmd.resp_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

[rtl/alle_dpath.sv]
// ----------------------------------------------------------------------------
// alle_dpath
// Link memories, free chain head, counters and result register of the
// linked list engine.
// ----------------------------------------------------------------------------
module alle_dpath #(
  parameter int DEPTH     = 256,
  parameter int ELEM_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  alle_pkg::in_item_t  in_data,
  input  alle_pkg::dp_cmd_t   cmd,
  output alle_pkg::dp_sts_t   sts,
  output alle_pkg::out_item_t out_data
);
  import alle_pkg::*;

  localparam int          AW      = $clog2(DEPTH);
  localparam int          CW      = $clog2(DEPTH + 1);
  localparam logic [31:0] DEPTH_L = 32'(DEPTH);

  // memories
  logic [ELEM_BITS-1:0] payload_mem [DEPTH];
  logic [AW-1:0]        next_mem    [DEPTH];
  logic [AW-1:0]        prev_mem    [DEPTH];

  // item registers
  op_t              op_r;
  logic [IDX_W-1:0] idx_r;
  logic [VAL_W-1:0] val_r;

  // list state
  logic [AW-1:0] free_head_r, free_head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          flag_r, flag_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [AW-1:0] init_r, init_nxt;

  // work registers
  logic [AW-1:0]    slot_r, slot_nxt;
  status_t          status_r, status_nxt;
  logic [IDX_W-1:0] rem_r, rem_nxt;
  logic [AW-1:0]    nx_r, pv_r;
  logic [AW-1:0]    next_rd_r, prev_rd_r;
  out_item_t        out_r;

  // memory ports
  logic [AW-1:0] next_raddr;
  logic          next_we;
  logic [AW-1:0] next_waddr, next_wdata;
  logic          prev_we;
  logic [AW-1:0] prev_waddr, prev_wdata;

  logic [AW-1:0] idx_a;
  logic          in_range;
  logic          ins_ok, rem_ok, find_ok;

  assign idx_a = AW'(idx_r);

  always_comb begin
    in_range = (32'(idx_r) < DEPTH_L);
    ins_ok   = in_range && (free_head_r != '0) && (32'(count_r) < DEPTH_L);
    rem_ok   = in_range && (idx_r != '0) && (count_r != '0);
    find_ok  = (32'(idx_r) <= 32'(count_r));
  end

  always_comb begin
    sts           = '0;
    sts.op        = op_r;
    sts.ins_ok    = ins_ok;
    sts.rem_ok    = rem_ok;
    sts.find_go   = find_ok && (idx_r != '0);
    sts.find_last = (rem_r == IDX_W'(1));
    sts.init_last = (init_r == AW'(DEPTH - 1));
  end

  // read address of the next-link memory
  always_comb begin
    next_raddr = head_r;
    if (cmd.decode) begin
      case (op_r)
        OP_INSERT: next_raddr = free_head_r;
        OP_REMOVE: next_raddr = idx_a;
        default:   next_raddr = head_r;
      endcase
    end else if (cmd.ins_b) begin
      next_raddr = idx_a;
    end else if (cmd.find_step) begin
      next_raddr = next_rd_r;
    end
  end

  // write ports
  always_comb begin
    next_we    = 1'b0;
    next_waddr = init_r;
    next_wdata = '0;
    prev_we    = 1'b0;
    prev_waddr = init_r;
    prev_wdata = '0;
    if (cmd.init_wr) begin
      next_we    = 1'b1;
      next_waddr = init_r;
      next_wdata = (init_r == '0 || init_r == AW'(DEPTH - 1)) ? '0 : init_r + AW'(1);
      prev_we    = 1'b1;
      prev_waddr = init_r;
      prev_wdata = '0;
    end else if (cmd.ins_b) begin
      prev_we    = 1'b1;
      prev_waddr = slot_r;
      prev_wdata = idx_a;
    end else if (cmd.ins_c) begin
      next_we    = 1'b1;
      next_waddr = slot_r;
      next_wdata = next_rd_r;
      prev_we    = 1'b1;
      prev_waddr = next_rd_r;
      prev_wdata = slot_r;
    end else if (cmd.ins_d) begin
      next_we    = 1'b1;
      next_waddr = idx_a;
      next_wdata = slot_r;
    end else if (cmd.rem_b) begin
      next_we    = 1'b1;
      next_waddr = idx_a;
      next_wdata = free_head_r;
      prev_we    = 1'b1;
      prev_waddr = next_rd_r;
      prev_wdata = prev_rd_r;
    end else if (cmd.rem_c) begin
      next_we    = 1'b1;
      next_waddr = pv_r;
      next_wdata = nx_r;
      prev_we    = 1'b1;
      prev_waddr = idx_a;
      prev_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (next_we) next_mem[next_waddr] <= next_wdata;
    next_rd_r <= next_mem[next_raddr];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
    prev_rd_r <= prev_mem[idx_a];
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_b) payload_mem[slot_r] <= ELEM_BITS'(val_r);
  end

  // list state next values
  always_comb begin
    free_head_nxt = free_head_r;
    count_nxt     = count_r;
    flag_nxt      = flag_r;
    init_nxt      = cmd.init_wr ? init_r + AW'(1) : init_r;
    slot_nxt      = slot_r;
    status_nxt    = status_r;
    rem_nxt       = rem_r;

    // entry 0 of each link memory is mirrored for the sentinel tests
    head_nxt = (next_we && next_waddr == '0) ? next_wdata : head_r;
    tail_nxt = (prev_we && prev_waddr == '0) ? prev_wdata : tail_r;

    if (cmd.decode) begin
      slot_nxt   = '0;
      status_nxt = ST_OK;
      rem_nxt    = idx_r;
      case (op_r)
        OP_INSERT: begin
          if (!in_range) begin
            status_nxt = ST_BADIDX;
          end else if (!ins_ok) begin
            status_nxt = ST_NOMEM;
          end else begin
            slot_nxt  = free_head_r;
            count_nxt = count_r + CW'(1);
            if (idx_r != '0 && 32'(idx_r) != 32'(tail_r)) flag_nxt = 1'b0;
          end
        end
        OP_REMOVE: begin
          // flag test comes before the index checks
          if (32'(idx_r) != 32'(head_r) && 32'(idx_r) != 32'(tail_r)) flag_nxt = 1'b0;
          if (!rem_ok) begin
            status_nxt = ST_BADIDX;
          end else begin
            count_nxt = count_r - CW'(1);
          end
        end
        OP_FIND: begin
          if (find_ok && idx_r == '0) slot_nxt = head_r;
        end
        default: begin
          status_nxt = ST_OK;
        end
      endcase
    end

    if (cmd.ins_b) free_head_nxt = next_rd_r;
    if (cmd.rem_b) free_head_nxt = idx_a;

    if (cmd.find_step) begin
      slot_nxt = next_rd_r;
      rem_nxt  = rem_r - IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= AW'(1);
      count_r     <= '0;
      flag_r      <= 1'b1;
      head_r      <= '0;
      tail_r      <= '0;
      init_r      <= '0;
    end else begin
      free_head_r <= free_head_nxt;
      count_r     <= count_nxt;
      flag_r      <= flag_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      init_r      <= init_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r   <= slot_nxt;
    status_r <= status_nxt;
    rem_r    <= rem_nxt;
    if (cmd.load) begin
      op_r  <= in_data.op;
      idx_r <= in_data.index;
      val_r <= in_data.value;
    end
    if (cmd.rem_b) begin
      nx_r <= next_rd_r;
      pv_r <= prev_rd_r;
    end
    if (cmd.resp_load) begin
      out_r.status <= status_r;
      out_r.slot   <= SLOT_W'(slot_r);
      out_r.linear <= flag_r;
      out_r.count  <= CNT_W'(count_r);
    end
  end

  assign out_data = out_r;

endmodule

[rtl/array_linked_list_engine.sv]
// ----------------------------------------------------------------------------
// array_linked_list_engine
// Doubly linked list in link memories with a sentinel slot and a free chain.
// ----------------------------------------------------------------------------
// After reset the block sweeps both link memories once, one slot a cycle, and
// takes no item until the last slot is written. Then it works on one item at
// a time: after the decode state, a query, a rejected insert or remove, or a
// find of position 0 or past the count goes straight to the result state; a
// remove first passes REM_B and REM_C, an insert INS_B, INS_C and INS_D, and
// any other find stays in FIND_B for as many links as its index. The next-link
// memory has a single registered read port: each link step waits for its read
// data, and a find follows one link per cycle. The next item is taken the
// cycle after its result is loaded, even if a stalled receiver still holds it.
module array_linked_list_engine #(
  parameter int DEPTH     = 256,
  parameter int ELEM_BITS = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  alle_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output alle_pkg::out_item_t out_data
);
  import alle_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  alle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  alle_dpath #(
    .DEPTH     (DEPTH),
    .ELEM_BITS (ELEM_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

[rtl/alle_checker.sv]
// ----------------------------------------------------------------------------
// alle_checker
// Port-level checks for the linked list engine, bound to the top level.
// ----------------------------------------------------------------------------
module alle_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input alle_pkg::out_item_t out_data
);
  import alle_pkg::*;

  logic             out_xfer;
  logic             seen_r;
  logic [CNT_W-1:0] last_cnt_r;
  logic             last_lin_r;

  assign out_xfer = out_valid && !out_stall;

  // remembers the previous result transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (out_xfer) begin
      seen_r <= 1'b1;
    end
    if (out_xfer) begin
      last_cnt_r <= out_data.count;
      last_lin_r <= out_data.linear;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_fail_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.slot == '0)
    else $error("failed operation reports a slot");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && seen_r |->
      out_data.count == last_cnt_r ||
      out_data.count == CNT_W'(last_cnt_r + 1'b1) ||
      out_data.count == CNT_W'(last_cnt_r - 1'b1))
    else $error("count moved by more than one");

  a_linear_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_xfer && seen_r && !last_lin_r |-> !out_data.linear)
    else $error("linear flag set again");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while busy");

endmodule

bind array_linked_list_engine alle_checker u_alle_checker (.*);

[tb/tb_array_linked_list_engine.sv]
// ----------------------------------------------------------------------------
// tb_array_linked_list_engine
// Self-checking bench for the array linked list engine. Inserts, removes,
// finds and queries are driven through the valid/stall input channel. A
// behavioural copy of the link arrays, the free chain, the element count and
// the linear flag predicts every result. Each result is compared field by
// field, in order, while in some tests the input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module tb_array_linked_list_engine;
  import alle_pkg::*;

  localparam int DEPTH      = 256;
  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_WAIT  = 20;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  array_linked_list_engine #(
    .DEPTH     (DEPTH),
    .ELEM_BITS (8)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // list image kept by the bench
  logic [7:0] link_fwd   [DEPTH];
  logic [7:0] link_back  [DEPTH];
  bit         back_known [DEPTH];
  logic [7:0] free_top;
  int         elem_count;
  logic       order_linear;

  out_item_t  expected_results[$];
  int         mismatches  = 0;
  int         idle_cycles = 0;
  int         idle_pct    = 0;
  int         stall_pct   = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic out_item_t apply_list_op(in_item_t it);
    out_item_t  r;
    logic [7:0] f;
    logic [7:0] after_slot;
    logic [7:0] old_top;
    logic [7:0] nx;
    logic [7:0] pv;
    logic [7:0] p;
    r        = '0;
    r.status = ST_OK;
    case (it.op)
      OP_INSERT: begin
        if (free_top == 0 || elem_count >= DEPTH) begin
          r.status = ST_NOMEM;
        end else begin
          f = free_top;
          if (it.index != 0 && it.index != link_back[0]) order_linear = 1'b0;
          free_top             = link_fwd[f];
          after_slot           = link_fwd[it.index];
          link_back[f]         = it.index;
          back_known[f]        = 1'b1;
          link_fwd[f]          = after_slot;
          link_fwd[it.index]   = f;
          link_back[after_slot]  = f;
          back_known[after_slot] = 1'b1;
          elem_count++;
          r.slot = f;
        end
      end
      OP_REMOVE: begin
        // flag test comes ahead of the index check
        if (it.index != link_fwd[0] && it.index != link_back[0]) order_linear = 1'b0;
        if (it.index == 0 || elem_count == 0) begin
          r.status = ST_BADIDX;
        end else begin
          old_top            = free_top;
          nx                 = link_fwd[it.index];
          pv                 = link_back[it.index];
          free_top           = it.index;
          link_fwd[it.index] = old_top;
          link_fwd[pv]       = nx;
          link_back[nx]      = pv;
          back_known[nx]     = 1'b1;
          link_back[it.index] = 8'd0;
          elem_count--;
        end
      end
      OP_FIND: begin
        if (int'(it.index) <= elem_count) begin
          p = link_fwd[0];
          for (int i = 0; i < int'(it.index); i++) p = link_fwd[p];
          r.slot = p;
        end
      end
      default: ;
    endcase
    r.linear = order_linear;
    r.count  = elem_count[7:0];
    return r;
  endfunction

  function automatic logic [7:0] pick_live_slot();
    logic [7:0] p;
    int         pos;
    if (elem_count == 0) return 8'd0;
    pos = $urandom_range(elem_count - 1);
    p   = link_fwd[0];
    for (int i = 0; i < pos; i++) p = link_fwd[p];
    return p;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d, expected %0d (t=%0t)", what, got, want, $time);
    mismatches++;
  endtask

  // one transfer on the input channel, then predict its result
  task automatic send_op(op_t op, logic [7:0] idx, logic [7:0] val);
    in_item_t it;
    it.op    = op;
    it.index = idx;
    it.value = val;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    expected_results.push_back(apply_list_op(it));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_op(bit stale);
    int         pick;
    int         ins_pct;
    int         rem_pct;
    op_t        op;
    logic [7:0] idx;
    ins_pct = (elem_count < 8) ? 55 : (elem_count > 48) ? 25 : 35;
    rem_pct = ins_pct + ((elem_count > 48) ? 45 : 30);
    pick    = $urandom_range(99);
    idx     = pick_live_slot();
    if (pick < ins_pct) begin
      op = OP_INSERT;
      case ($urandom_range(3))
        0: idx = 8'd0;
        1: idx = link_back[0];
        default: ;
      endcase
      if (stale && $urandom_range(1)) idx = 8'($urandom_range(255));
      // only a broken free chain gets here; keeps the count in range
      if (free_top != 0 && elem_count >= DEPTH - 1) op = OP_QUERY;
    end else if (pick < rem_pct) begin
      op = OP_REMOVE;
      case ($urandom_range(4))
        0: idx = link_fwd[0];
        1: idx = link_back[0];
        2: if ($urandom_range(9) == 0) idx = 8'd0;
        default: ;
      endcase
      if (stale && $urandom_range(1)) idx = 8'($urandom_range(255));
      // a slot never linked has no back link to read
      if (idx != 0 && elem_count != 0 && !back_known[idx]) idx = 8'd0;
    end else if (pick < 92) begin
      op  = OP_FIND;
      idx = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) :
                                       8'($urandom_range(elem_count + 1));
    end else begin
      op = OP_QUERY;
    end
    send_op(op, idx, 8'($urandom_range(255)));
  endtask

  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    send_op(OP_QUERY, 8'd0, 8'h00);
    send_op(OP_FIND, 8'd0, 8'hFF);
    send_op(OP_FIND, 8'd1, 8'h00);
    send_op(OP_REMOVE, 8'd0, 8'h00);
    send_op(OP_INSERT, 8'd0, 8'h00);
    send_op(OP_INSERT, link_back[0], 8'hFF);
    send_op(OP_INSERT, 8'd0, 8'h5A);
    send_op(OP_FIND, 8'd0, 8'h00);
    send_op(OP_FIND, 8'd2, 8'h00);
    send_op(OP_FIND, 8'd3, 8'h00);
    send_op(OP_FIND, 8'd4, 8'h00);
    send_op(OP_FIND, 8'd255, 8'h00);
    send_op(OP_REMOVE, link_fwd[0], 8'h00);
    send_op(OP_REMOVE, link_back[0], 8'h00);
    send_op(OP_INSERT, 8'd0, 8'hA5);
    send_op(OP_INSERT, link_back[0], 8'h3C);
    send_op(OP_QUERY, 8'hFF, 8'hFF);
    // after the head, which is not the tail: linear flag drops
    send_op(OP_INSERT, link_fwd[0], 8'hC3);
    send_op(OP_REMOVE, link_fwd[link_fwd[0]], 8'h00);
    send_op(OP_REMOVE, 8'd0, 8'h00);
    send_op(OP_QUERY, 8'd0, 8'h00);
  endtask

  task automatic test_fill_and_drain();
    logic [7:0] idx;
    idle_pct  = 69;
    stall_pct = 0;
    while (free_top != 0) begin
      case ($urandom_range(2))
        0: idx = 8'd0;
        1: idx = link_back[0];
        default: idx = pick_live_slot();
      endcase
      send_op(OP_INSERT, idx, 8'($urandom_range(255)));
    end
    // free chain exhausted
    send_op(OP_INSERT, 8'd0, 8'($urandom_range(255)));
    send_op(OP_INSERT, pick_live_slot(), 8'($urandom_range(255)));
    send_op(OP_FIND, 8'd255, 8'h00);
    send_op(OP_FIND, 8'd254, 8'h00);
    send_op(OP_FIND, 8'($urandom_range(255)), 8'h00);
    while (elem_count != 0) begin
      case ($urandom_range(2))
        0: idx = link_fwd[0];
        1: idx = link_back[0];
        default: idx = pick_live_slot();
      endcase
      send_op(OP_REMOVE, idx, 8'($urandom_range(255)));
    end
    send_op(OP_REMOVE, 8'($urandom_range(255, 1)), 8'h00);
    send_op(OP_FIND, 8'd0, 8'h00);
    send_op(OP_QUERY, 8'd0, 8'h00);
  endtask

  task automatic test_random_lists();
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 69; end
        1: begin idle_pct = 20; stall_pct = 20; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      repeat (300) send_random_op(1'b0);
    end
  endtask

  task automatic test_stale_slots();
    idle_pct  = 20;
    stall_pct = 20;
    repeat (300) send_random_op(1'b1);
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing expected, slot", 32'(out_data.slot), 0);
      end else begin
        want = expected_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
        if (out_data.slot !== want.slot)
          report_mismatch("slot", 32'(out_data.slot), 32'(want.slot));
        if (out_data.linear !== want.linear)
          report_mismatch("linear", 32'(out_data.linear), 32'(want.linear));
        if (out_data.count !== want.count)
          report_mismatch("count", 32'(out_data.count), 32'(want.count));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin : main_seq
    for (int i = 0; i < DEPTH; i++) begin
      link_fwd[i]   = (i == 0 || i == DEPTH - 1) ? 8'd0 : 8'(i + 1);
      link_back[i]  = 8'd0;
      back_known[i] = (i == 0);
    end
    free_top     = 8'd1;
    elem_count   = 0;
    order_linear = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    wait_drained();
    test_fill_and_drain();
    wait_drained();
    test_random_lists();
    wait_drained();
    test_stale_slots();
    wait_drained();
    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[files.f]
rtl/alle_pkg.sv
rtl/alle_ctrl.sv
rtl/alle_dpath.sv
rtl/array_linked_list_engine.sv
rtl/alle_checker.sv
tb/tb_array_linked_list_engine.sv
